// ===== rtl/fifo_with_min_even_dup_stats_unit_macros.svh =====
// assertion macros for the queue statistics unit
`ifndef FIFO_WITH_MIN_EVEN_DUP_STATS_UNIT_MACROS_SVH
`define FIFO_WITH_MIN_EVEN_DUP_STATS_UNIT_MACROS_SVH
// implication checked every edge outside reset
`define FQS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// shared types and constants of the queue statistics unit
// ----------------------------------------------------------------------------
package fqs_pkg;
  localparam int DEPTH = 16;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_SCAN, ST_PAIR_I, ST_PAIR_LD, ST_PAIR_CMP, ST_DONE
  } fqs_state_t;

  typedef struct packed {
    logic start;    // latch request, update pointers, read head
    logic scan;     // accumulate stats over i, read i + 1
    logic pair_ld;  // latch held(i), read held(i + 1)
    logic pair_cmp; // compare held(j) with held(i), read held(j + 1)
  } fqs_cmd_t;

  typedef struct packed {
    logic last_i;   // i is the last held offset
    logic last_j;   // j is the last held offset
    logic hit;      // held(j) equals held(i)
  } fqs_stat_t;
endpackage

// ===== rtl/fqs_ram.sv =====
// ----------------------------------------------------------------------------
// fqs_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/fqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqs_ctrl
// sequencer: statistics pass, then pairwise duplicate search
// ----------------------------------------------------------------------------
module fqs_ctrl import fqs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fqs_stat_t stat,
  output fqs_cmd_t  cmd
);
  fqs_state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_RD;
      ST_RD: state_next = ST_SCAN;
      ST_SCAN: if (stat.last_i) state_next = ST_PAIR_I;
      ST_PAIR_I: state_next = stat.last_i ? ST_DONE : ST_PAIR_LD;
      ST_PAIR_LD: state_next = ST_PAIR_CMP;
      ST_PAIR_CMP: begin
        if (stat.hit) state_next = ST_DONE;
        else if (stat.last_j) state_next = ST_PAIR_I;
      end
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN: cmd.scan = 1'b1;
      ST_PAIR_LD: cmd.pair_ld = 1'b1;
      ST_PAIR_CMP: cmd.pair_cmp = 1'b1;
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== rtl/fqs_dp.sv =====
// ----------------------------------------------------------------------------
// fqs_dp
// queue storage, pointers and statistics accumulators
// ----------------------------------------------------------------------------
module fqs_dp import fqs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  fqs_cmd_t           cmd,
  output fqs_stat_t          stat,
  input  logic               req_type,
  input  logic signed [31:0] value,
  output logic signed [31:0] popped_value,
  output logic               underflow,
  output logic               overflow,
  output logic [4:0]         occupancy,
  output logic [4:0]         even_count,
  output logic signed [31:0] min_value,
  output logic               is_empty,
  output logic [3:0]         dup_distance
);
  logic [AW-1:0] head, tail;
  logic [CW-1:0] count;
  logic [CW-1:0] i, j;   // offsets from head
  logic [31:0]   ri;     // held(i) latched for the pair search
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic          do_push, do_pop, pop_pending;
  logic [CW:0]   pos;
  logic [CW-1:0] off;
  logic [CW-1:0] ev;
  logic [CW-1:0] gap;

  assign do_push = cmd.start && req_type == REQ_PUSH && count != CW'(DEPTH);
  assign do_pop = cmd.start && req_type == REQ_POP && count != '0;

  // read one entry ahead while scanning and comparing
  always_comb begin
    if (cmd.scan || cmd.pair_ld) off = i + CW'(1);
    else if (cmd.pair_cmp) off = j + CW'(1);
    else off = i;
  end

  // physical address of head + offset, modulo depth
  always_comb begin
    pos = (CW+1)'(head) + (CW+1)'(off);
    if (pos >= (CW+1)'(DEPTH)) pos = pos - (CW+1)'(DEPTH);
    raddr = cmd.start ? head : pos[AW-1:0];
  end

  fqs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(do_push), .waddr(tail), .wdata(value),
    .raddr(raddr), .rdata(rdata)
  );

  assign stat.last_i = (i + CW'(1)) >= count;
  assign stat.last_j = (j + CW'(1)) >= count;
  assign stat.hit = rdata == ri;
  assign gap = j - i;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
      pop_pending <= 1'b0;
    end else begin
      pop_pending <= do_pop;
      if (do_push) begin
        tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + AW'(1);
        count <= count + CW'(1);
      end else if (do_pop) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      underflow <= req_type == REQ_POP && count == '0;
      overflow <= req_type == REQ_PUSH && count == CW'(DEPTH);
    end

    if (cmd.start) popped_value <= '0;
    else if (pop_pending) popped_value <= rdata;

    if (cmd.start) begin
      ev <= '0;
      min_value <= '0;
    end else if (cmd.scan && count != '0) begin
      if (!rdata[0]) ev <= ev + CW'(1);
      if (i == '0 || $signed(rdata) < min_value) min_value <= rdata;
    end

    if (cmd.start) i <= '0;
    else if (cmd.scan) i <= stat.last_i ? '0 : i + CW'(1);
    else if (cmd.pair_cmp && !stat.hit && stat.last_j) i <= i + CW'(1);

    if (cmd.pair_ld) j <= i + CW'(1);
    else if (cmd.pair_cmp && !stat.hit && !stat.last_j) j <= j + CW'(1);

    if (cmd.pair_ld) ri <= rdata;

    if (cmd.start) dup_distance <= '0;
    else if (cmd.pair_cmp && stat.hit) dup_distance <= gap[3:0];
  end

  assign occupancy = 5'(count);
  assign even_count = 5'(ev);
  assign is_empty = count == '0;
endmodule

// ===== rtl/fifo_with_min_even_dup_stats_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_with_min_even_dup_stats_unit
// bounded queue of signed words with per-request statistics
// ----------------------------------------------------------------------------
// Each request is a push or pop; one result follows with popped word, flags,
// occupancy, even count, minimum and duplicate distance. Requests are taken
// one at a time: in_ready is high only while idle. After acceptance the unit
// passes through a read state, then scans the held entries for even count
// and minimum, then runs the pair search: the pair-index and pair-load states
// fetch each outer entry and one compare runs per cycle on the single ram
// read port, stopping at the first duplicate. Once the result is taken the
// unit returns to idle before the next request is accepted. No clearing
// pass after reset.
module fifo_with_min_even_dup_stats_unit import fqs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] popped_value,
  output logic               underflow,
  output logic               overflow,
  output logic [4:0]         occupancy,
  output logic [4:0]         even_count,
  output logic signed [31:0] min_value,
  output logic               is_empty,
  output logic [3:0]         dup_distance
);
  fqs_cmd_t  cmd;
  fqs_stat_t stat;

  fqs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  fqs_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .req_type(req_type),
    .value(value), .popped_value(popped_value), .underflow(underflow),
    .overflow(overflow), .occupancy(occupancy), .even_count(even_count),
    .min_value(min_value), .is_empty(is_empty), .dup_distance(dup_distance)
  );
endmodule

// ===== rtl/fqs_checker.sv =====
// ----------------------------------------------------------------------------
// fqs_checker
// port-level checks of the queue statistics unit
// ----------------------------------------------------------------------------
`include "fifo_with_min_even_dup_stats_unit_macros.svh"
module fqs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       underflow,
  input logic       overflow,
  input logic [4:0] occupancy,
  input logic       is_empty,
  input logic [3:0] dup_distance
);
  `FQS_ASSERT_IMP(a_one_at_a_time, clk, rst, out_valid, !in_ready)
  `FQS_ASSERT_IMP(a_empty_match, clk, rst, out_valid, is_empty == (occupancy == 5'd0))
  `FQS_ASSERT_IMP(a_flags_excl, clk, rst, out_valid, !(underflow && overflow))
  `FQS_ASSERT_IMP(a_dup_needs_two, clk, rst, out_valid && occupancy < 5'd2, dup_distance == 4'd0)
  `FQS_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)
endmodule

bind fifo_with_min_even_dup_stats_unit fqs_checker u_fqs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .underflow(underflow),
  .overflow(overflow), .occupancy(occupancy), .is_empty(is_empty),
  .dup_distance(dup_distance)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// queue statistics unit bench
// drives push and pop requests, predicts each result from a local model of
// the queue and compares popped word, flags, occupancy and statistics
// ----------------------------------------------------------------------------
class queue_stats_board;
  logic signed [31:0] held_q[$];
  logic [80:0] want_q[$];
  int errors;
  int results;

  function void note_request(logic rt, logic signed [31:0] v);
    logic signed [31:0] popped;
    logic under, over, found;
    logic [4:0] evens;
    logic signed [31:0] minv;
    logic [3:0] dup;
    popped = 0; under = 0; over = 0; evens = 0; minv = 0; dup = 0; found = 0;
    if (rt == fqs_pkg::REQ_PUSH) begin
      if (held_q.size() >= fqs_pkg::DEPTH) over = 1;
      else held_q.push_back(v);
    end else begin
      if (held_q.size() == 0) under = 1;
      else popped = held_q.pop_front();
    end
    foreach (held_q[i]) begin
      if (!held_q[i][0]) evens++;
      if (i == 0 || held_q[i] < minv) minv = held_q[i];
    end
    for (int i = 0; i + 1 < held_q.size() && !found; i++)
      for (int j = i + 1; j < held_q.size() && !found; j++)
        if (held_q[j] == held_q[i]) begin
          dup = 4'(j - i);
          found = 1;
        end
    want_q.push_back({popped, under, over, 5'(held_q.size()), evens, minv,
                      held_q.size() == 0, dup});
  endfunction

  function void check_result(logic [80:0] got);
    logic [80:0] exp;
    results++;
    if (want_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = want_q.pop_front();
    if (exp[80:49] !== got[80:49]) begin
      $display("%0t: popped_value exp %0d got %0d", $time,
               $signed(exp[80:49]), $signed(got[80:49])); errors++;
    end
    if (exp[48] !== got[48]) begin
      $display("%0t: underflow exp %0b got %0b", $time, exp[48], got[48]); errors++;
    end
    if (exp[47] !== got[47]) begin
      $display("%0t: overflow exp %0b got %0b", $time, exp[47], got[47]); errors++;
    end
    if (exp[46:42] !== got[46:42]) begin
      $display("%0t: occupancy exp %0d got %0d", $time, exp[46:42], got[46:42]); errors++;
    end
    if (exp[41:37] !== got[41:37]) begin
      $display("%0t: even_count exp %0d got %0d", $time, exp[41:37], got[41:37]); errors++;
    end
    if (exp[36:5] !== got[36:5]) begin
      $display("%0t: min_value exp %0d got %0d", $time,
               $signed(exp[36:5]), $signed(got[36:5])); errors++;
    end
    if (exp[4:0] !== got[4:0]) begin
      $display("%0t: empty/dup exp %0b/%0d got %0b/%0d", $time, exp[4], exp[3:0],
               got[4], got[3:0]); errors++;
    end
  endfunction
endclass

module tb;
  import fqs_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic req_type = 0;
  logic signed [31:0] value = 0;
  logic out_ready = 0;
  logic in_ready, out_valid, underflow, overflow, is_empty;
  logic signed [31:0] popped_value, min_value;
  logic [4:0] occupancy, even_count;
  logic [3:0] dup_distance;

  queue_stats_board board = new();
  int send_idle_pct, recv_idle_pct;
  int sent;
  longint cycles;
  bit timed_out;

  always #2 clk = ~clk;

  fifo_with_min_even_dup_stats_unit uut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check_result({popped_value, underflow, overflow, occupancy, even_count,
                            min_value, is_empty, dup_distance});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays high into the next request when no idle cycle is drawn
  task automatic send(logic rt, logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    req_type <= rt;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(rt, v);
    sent++;
  endtask

  // values from a small pool so duplicates appear often
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return -$signed(32'($urandom_range(4)));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [31:0] edges[6];
    edges = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 32'sh5555_5555};
    repeat (3) @(posedge clk);
    rst <= 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    // pop when empty, extremes, duplicate pair, fill past full, partial drain
    send(REQ_POP, 32'sh1234_5678);
    foreach (edges[i]) send(REQ_PUSH, edges[i]);
    send(REQ_PUSH, -1);
    for (int i = 0; i < 10; i++) send(REQ_PUSH, i);
    send(REQ_PUSH, 32'shaaaa_aaaa);
    for (int i = 0; i < 6; i++) send(REQ_POP, 0);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 69 : 0;
      recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 21 : 0;
      for (int k = 0; k < 310; k++) begin
        int bias;
        bias = ((k / 40) % 3 == 0) ? 70 : ((k / 40) % 3 == 1) ? 30 : 50;
        if ($urandom_range(99) < bias) send(REQ_PUSH, pick_value());
        else send(REQ_POP, $urandom);
      end
    end
    in_valid <= 0;
    while (board.want_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d requests sent, %0d results checked across fill, drain, over/underflow",
             sent, board.results);
    $display("three idle mixes on both sides, values from edges and a duplicate-heavy pool");
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
